// ===== rtl/basu_pkg.sv =====
// Shared types and constants for the bounded array store engine.
package basu_pkg;

  // Number of entry cells in the chain.
  localparam int unsigned DEPTH = 64;

  // Width of the fill count. It holds every value from zero to DEPTH.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Width of the position field and of the fill count field at the ports.
  localparam int unsigned POS_W = 7;

  // Width of a stored word.
  localparam int unsigned WORD_W = 32;

  // Width used for index comparisons inside the cells.
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request codes.
  typedef enum logic [2:0] {
    ACT_PUSH     = 3'd0,
    ACT_POP      = 3'd1,
    ACT_GET      = 3'd2,
    ACT_SET      = 3'd3,
    ACT_INSERT   = 3'd4,
    ACT_CONTAINS = 3'd5
  } action_e;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic              wr_en;    // write word at wr_pos
    logic              shift_en; // cells above wr_pos up to top_pos take their lower neighbor
    logic [CMP_W-1:0]  wr_pos;
    logic [CMP_W-1:0]  top_pos;  // current fill count, highest cell touched by an insert
    logic [CMP_W-1:0]  rd_pos;
    logic [WORD_W-1:0] word;
  } cell_ctrl_t;

endpackage

// ===== rtl/basu_cell.sv =====
// One entry cell of the store chain: holds a word, shifts, compares and drives the read bus.
module basu_cell import basu_pkg::*; (
  input  logic              clk_i,
  input  logic [CMP_W-1:0]  idx_i,      // this cell's fixed place in the chain
  input  cell_ctrl_t        ctrl_i,
  input  logic [WORD_W-1:0] prev_i,     // word of the lower neighbor
  output logic [WORD_W-1:0] word_o,     // word handed to the upper neighbor
  output logic              match_o,    // held word is valid and equals the search word
  output logic [WORD_W-1:0] rd_o        // held word when addressed, zero otherwise
);

  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] word_d;
  logic              load_new;
  logic              load_prev;

  // A write at this place wins; otherwise an insert below moves the lower word up.
  always_comb begin
    load_new  = ctrl_i.wr_en && (idx_i == ctrl_i.wr_pos);
    load_prev = ctrl_i.shift_en && (idx_i > ctrl_i.wr_pos) && (idx_i <= ctrl_i.top_pos);
    word_d    = word_q;
    if (load_new) begin
      word_d = ctrl_i.word;
    end else if (load_prev) begin
      word_d = prev_i;
    end
  end

  // Payload storage needs no reset: only places below the count are ever read.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // Search compare and gated read for the shared OR bus.
  assign word_o  = word_q;
  assign match_o = (idx_i < ctrl_i.top_pos) && (word_q == ctrl_i.word);
  assign rd_o    = (idx_i == ctrl_i.rd_pos) ? word_q : '0;

endmodule

// ===== rtl/bounded_array_store_engine_unit.sv =====
// Top level of the bounded array store engine: request decode, count and the chain of cells.
//
// The block takes one request per clock cycle and never raises busy; the result word
// appears on the result ports, marked by done_o, in the cycle right after the request is
// accepted, and done_o marks it for one cycle only. The rate is set by the chain of 64
// entry cells, each of which shifts, loads or compares on its own, so an insert
// moves all later words and a contains search checks all stored words at once. The store
// needs no clearing pass after reset and can take a request as soon as reset is released.
module bounded_array_store_engine_unit import basu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               action_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [WORD_W-1:0] word_in_i,
  output logic                     done_o,
  output logic                     status_o,
  output logic signed [WORD_W-1:0] word_out_o,
  output logic                     found_o,
  output logic [POS_W-1:0]         fill_count_o
);

  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;
  logic              accept;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  cnt_x;
  logic              full;
  logic              empty;
  logic              err;
  logic              rd_req;
  cell_ctrl_t        ctrl;
  logic [WORD_W-1:0] chain [DEPTH+1];
  logic [WORD_W-1:0] rd_bus [DEPTH];
  logic [DEPTH-1:0]  match;
  logic [WORD_W-1:0] rd_word;

  logic              done_q;
  logic              status_q;
  logic [WORD_W-1:0] word_out_q;
  logic              found_q;
  logic [POS_W-1:0]  fill_q;

  // Every request is processed in the cycle it is accepted, so busy is tied low.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_x = CMP_W'(position_i);
  assign cnt_x = CMP_W'(count_q);
  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // Request decode: error check, cell control and the next count.
  always_comb begin
    err           = 1'b0;
    rd_req        = 1'b0;
    count_d       = count_q;
    ctrl.wr_en    = 1'b0;
    ctrl.shift_en = 1'b0;
    ctrl.wr_pos   = pos_x;
    ctrl.top_pos  = cnt_x;
    ctrl.rd_pos   = pos_x;
    ctrl.word     = word_in_i;
    case (action_i)
      ACT_PUSH: begin
        err         = full;
        ctrl.wr_pos = cnt_x;
        ctrl.wr_en  = accept && !full;
        if (accept && !full) begin
          count_d = count_q + 1'b1;
        end
      end
      ACT_POP: begin
        err         = empty;
        rd_req      = 1'b1;
        ctrl.rd_pos = cnt_x - 1'b1;
        if (accept && !empty) begin
          count_d = count_q - 1'b1;
        end
      end
      ACT_GET: begin
        err    = (pos_x >= cnt_x);
        rd_req = 1'b1;
      end
      ACT_SET: begin
        err        = (pos_x >= cnt_x);
        ctrl.wr_en = accept && !err;
      end
      ACT_INSERT: begin
        err           = (pos_x > cnt_x) || full;
        ctrl.wr_en    = accept && !err;
        ctrl.shift_en = accept && !err;
        if (accept && !err) begin
          count_d = count_q + 1'b1;
        end
      end
      ACT_CONTAINS: begin
        err = 1'b0;
      end
      default: begin
        err = 1'b1;
      end
    endcase
  end

  // The chain of entry cells; the lowest cell sees a zero neighbor.
  assign chain[0] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    basu_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (CMP_W'(g)),
      .ctrl_i  (ctrl),
      .prev_i  (chain[g]),
      .word_o  (chain[g+1]),
      .match_o (match[g]),
      .rd_o    (rd_bus[g])
    );
  end

  // OR the gated cell outputs into the read word; only the addressed cell drives nonzero.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | rd_bus[i];
    end
  end

  // Fill count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  // Result word registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= err;
      word_out_q <= (rd_req && !err) ? rd_word : '0;
      found_q    <= (action_i == ACT_CONTAINS) && (|match);
      fill_q     <= POS_W'(CMP_W'(count_d));
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign word_out_o   = word_out_q;
  assign found_o      = found_q;
  assign fill_count_o = fill_q;

  // The count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // Every accepted request gives a result in the next cycle.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("missing result after accepted request");

  // No result appears without a request.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result without request");

  // A failed request leaves the count unchanged.
  a_err_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && err) |=> (count_q == $past(count_q)))
    else $error("failed request changed the count");

  // A found flag only comes with a successful result.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> !status_o)
    else $error("found flag on an error result");

endmodule

// ===== sim/tb_bounded_array_store_engine_unit.sv =====
// Self-checking testbench for the bounded array store engine, with its own store predictor.
module tb_bounded_array_store_engine_unit;
  import basu_pkg::*;

  localparam int unsigned RANDOM_WORDS = 800;
  localparam int unsigned CALM_TAIL    = 100;
  localparam int unsigned CYCLE_LIMIT  = 50000;
  localparam int unsigned DRAIN_CYCLES = 4;

  // Action codes that the block does not define.
  localparam logic [2:0] ACT_RSVD_LO = 3'd6;
  localparam logic [2:0] ACT_RSVD_HI = 3'd7;

  // One expected result word.
  typedef struct packed {
    logic              status;
    logic [WORD_W-1:0] word;
    logic              found;
    logic [POS_W-1:0]  fill;
  } store_result_t;

  // Shadow copy of the store and the queue of results it predicts.
  class store_scoreboard;
    logic [WORD_W-1:0] cells [DEPTH];
    int unsigned       fill = 0;
    store_result_t     expected_q [$];
    int unsigned       mismatches = 0;
    int unsigned       results_seen = 0;

    task report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    // Apply one accepted request word to the shadow store and queue its result.
    function void note_request(input logic [2:0] act, input logic [POS_W-1:0] pos,
                               input logic [WORD_W-1:0] w);
      store_result_t r;
      int unsigned   i;
      r = '0;
      case (act)
        ACT_PUSH: begin
          if (fill >= DEPTH) begin
            r.status = 1'b1;
          end else begin
            cells[fill] = w;
            fill++;
          end
        end
        ACT_POP: begin
          if (fill == 0) begin
            r.status = 1'b1;
          end else begin
            fill--;
            r.word = cells[fill];
          end
        end
        ACT_GET: begin
          if (pos >= fill) r.status = 1'b1;
          else r.word = cells[pos];
        end
        ACT_SET: begin
          if (pos >= fill) r.status = 1'b1;
          else cells[pos] = w;
        end
        ACT_INSERT: begin
          // A position equal to the count behaves like a push.
          if (pos > fill || fill >= DEPTH) begin
            r.status = 1'b1;
          end else begin
            for (i = fill; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = w;
            fill++;
          end
        end
        ACT_CONTAINS: begin
          for (i = 0; i < fill; i++) begin
            if (cells[i] == w) r.found = 1'b1;
          end
        end
        default: r.status = 1'b1;
      endcase
      r.fill = POS_W'(fill);
      expected_q.push_back(r);
    endfunction

    // Compare one result word with the oldest expectation.
    task check_result(input logic st, input logic [WORD_W-1:0] w, input logic fd,
                      input logic [POS_W-1:0] fc);
      store_result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        e = expected_q.pop_front();
        if (st !== e.status)
          report_mismatch($sformatf("result %0d status: got %b, expected %b",
                                    results_seen, st, e.status));
        if (w !== e.word)
          report_mismatch($sformatf("result %0d word_out: got %h, expected %h",
                                    results_seen, w, e.word));
        if (fd !== e.found)
          report_mismatch($sformatf("result %0d found: got %b, expected %b",
                                    results_seen, fd, e.found));
        if (fc !== e.fill)
          report_mismatch($sformatf("result %0d fill_count: got %0d, expected %0d",
                                    results_seen, fc, e.fill));
      end
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [2:0]               action_i;
  logic [POS_W-1:0]         position_i;
  logic signed [WORD_W-1:0] word_in_i;
  logic                     done_o;
  logic                     status_o;
  logic signed [WORD_W-1:0] word_out_o;
  logic                     found_o;
  logic [POS_W-1:0]         fill_count_o;

  store_scoreboard sb;

  bounded_array_store_engine_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .position_i   (position_i),
    .word_in_i    (word_in_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .word_out_o   (word_out_o),
    .found_o      (found_o),
    .fill_count_o (fill_count_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Every strobed result word is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (done_o === 1'b1) sb.check_result(status_o, word_out_o, found_o, fill_count_o);
      else if (done_o !== 1'b0) sb.report_mismatch("result strobe is unknown");
    end
  end

  // Hard stop for a hung run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  // Offer one request word, wait for its acceptance, then maybe pause for a burst.
  task automatic send_request(input logic [2:0] act, input logic [POS_W-1:0] pos,
                              input logic [WORD_W-1:0] w, input bit idle_ok);
    int unsigned gap;
    start      <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    word_in_i  <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(act, pos, w);
    if (idle_ok && $urandom_range(99) < 20) begin
      gap = $urandom_range(5, 1);
      // Junk on the request fields while start is low must be ignored.
      start      <= 1'b0;
      action_i   <= 3'($urandom());
      position_i <= POS_W'($urandom());
      word_in_i  <= $urandom();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [WORD_W-1:0] word_pool [8];
    logic [2:0]        act;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] w;
    bit                growing;
    int unsigned       edge_hits;
    int unsigned       edge_stay;
    int unsigned       r;
    int unsigned       n;

    sb = new;
    start      <= 1'b0;
    action_i   <= '0;
    position_i <= '0;
    word_in_i  <= '0;
    rst_ni     <= 1'b0;
    for (n = 0; n < 8; n++) word_pool[n] = (n < 4) ? WORD_W'(n) : $urandom();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty-store errors, boundary inserts, field extremes, every action.
    send_request(ACT_POP,      7'd0,  32'h0000_0000, 1'b1);
    send_request(ACT_GET,      7'd0,  32'h0000_0000, 1'b1);
    send_request(ACT_SET,      7'd0,  32'hDEAD_BEEF, 1'b1);
    send_request(ACT_CONTAINS, 7'd0,  32'h0000_0000, 1'b1);
    send_request(ACT_INSERT,   7'd0,  32'h0000_0001, 1'b1);
    send_request(ACT_PUSH,     7'd0,  32'h7FFF_FFFF, 1'b1);
    send_request(ACT_PUSH,     7'd64, 32'h8000_0000, 1'b1);
    send_request(ACT_PUSH,     7'd0,  32'hFFFF_FFFF, 1'b1);
    send_request(ACT_INSERT,   7'd1,  32'h5555_5555, 1'b1);
    send_request(ACT_INSERT,   7'd5,  32'hAAAA_AAAA, 1'b1);
    send_request(ACT_INSERT,   7'd7,  32'h1111_1111, 1'b1);
    send_request(ACT_GET,      7'd0,  32'h0000_0000, 1'b1);
    send_request(ACT_GET,      7'd5,  32'h0000_0000, 1'b1);
    send_request(ACT_GET,      7'd6,  32'h0000_0000, 1'b1);
    send_request(ACT_GET,      7'd64, 32'h0000_0000, 1'b1);
    send_request(ACT_SET,      7'd2,  32'h1234_5678, 1'b1);
    send_request(ACT_SET,      7'd6,  32'h8765_4321, 1'b1);
    send_request(ACT_CONTAINS, 7'd0,  32'h8000_0000, 1'b1);
    send_request(ACT_CONTAINS, 7'd3,  32'h1234_5678, 1'b1);
    send_request(ACT_CONTAINS, 7'd0,  32'h0000_0002, 1'b1);
    send_request(ACT_RSVD_LO,  7'd0,  32'h0000_0000, 1'b1);
    send_request(ACT_RSVD_HI,  7'd64, 32'hFFFF_FFFF, 1'b1);
    send_request(ACT_POP,      7'd0,  32'h0000_0000, 1'b1);
    send_request(ACT_POP,      7'd0,  32'h0000_0000, 1'b1);
    send_request(ACT_PUSH,     7'd0,  32'h0000_0000, 1'b1);

    // Random part: sweep the fill count between empty and full, lingering at each end.
    growing   = 1'b1;
    edge_hits = 0;
    edge_stay = $urandom_range(6, 2);
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if ((growing && sb.fill == DEPTH) || (!growing && sb.fill == 0)) begin
        edge_hits++;
        if (edge_hits > edge_stay) begin
          growing   = !growing;
          edge_hits = 0;
          edge_stay = $urandom_range(6, 2);
        end
      end

      // Action mix leans toward growth or shrinkage, with a little undefined noise.
      r = $urandom_range(99);
      if (growing) begin
        if (r < 35) act = ACT_PUSH;
        else if (r < 65) act = ACT_INSERT;
        else if (r < 73) act = ACT_GET;
        else if (r < 81) act = ACT_SET;
        else if (r < 91) act = ACT_CONTAINS;
        else if (r < 96) act = ACT_POP;
        else act = $urandom_range(1) ? ACT_RSVD_HI : ACT_RSVD_LO;
      end else begin
        if (r < 55) act = ACT_POP;
        else if (r < 62) act = ACT_PUSH;
        else if (r < 68) act = ACT_INSERT;
        else if (r < 76) act = ACT_GET;
        else if (r < 84) act = ACT_SET;
        else if (r < 94) act = ACT_CONTAINS;
        else act = $urandom_range(1) ? ACT_RSVD_HI : ACT_RSVD_LO;
      end

      // Positions are mostly in range, sometimes past the count.
      r = $urandom_range(99);
      if ((act == ACT_GET || act == ACT_SET) && sb.fill > 0 && r < 85)
        pos = POS_W'($urandom_range(sb.fill - 1));
      else if (act == ACT_GET || act == ACT_SET)
        pos = POS_W'($urandom_range(DEPTH, sb.fill));
      else if (act == ACT_INSERT && r < 85)
        pos = POS_W'($urandom_range(sb.fill));
      else if (act == ACT_INSERT)
        pos = POS_W'($urandom_range(DEPTH, (sb.fill < DEPTH) ? sb.fill + 1 : DEPTH));
      else
        pos = POS_W'($urandom_range(DEPTH));

      // Words from a small pool make contains hits common; extremes and full random too.
      r = $urandom_range(99);
      if (r < 40) begin
        w = word_pool[$urandom_range(7)];
      end else if (r < 50) begin
        case ($urandom_range(3))
          0: w = 32'h0000_0000;
          1: w = 32'hFFFF_FFFF;
          2: w = 32'h7FFF_FFFF;
          default: w = 32'h8000_0000;
        endcase
      end else begin
        w = $urandom();
      end

      send_request(act, pos, w, n < RANDOM_WORDS - CALM_TAIL);
    end
    start <= 1'b0;

    // Drain outstanding results, then keep clocking the idle block so a spurious result is caught.
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/basu_pkg.sv
rtl/basu_cell.sv
rtl/bounded_array_store_engine_unit.sv
sim/tb_bounded_array_store_engine_unit.sv
